[hdl/stack_allocator_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Stack allocator engine assertion macros
// Shared property templates for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef STACK_ALLOCATOR_ENGINE_TOP_DEFINES_SVH
`define STACK_ALLOCATOR_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sae_pkg.sv]
// ----------------------------------------------------------------------------
// Stack allocator engine package
// Codes, widths, control structs and the padding function.
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OFFS_W      = 21;
  localparam int unsigned BYTES_W     = 21;
  localparam int unsigned ALIGN_W     = 4;
  localparam int unsigned PAD_W       = 8;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned HDR_W       = PAD_W + OFFS_W;
  localparam int unsigned SUM_W       = OFFS_W + 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned POOL_MAX     = 1048576;
  localparam logic [OFFS_W-1:0] POOL_RESET = OFFS_W'(POOL_MAX);

  // alignment is clamped to 128 bytes
  localparam logic [2:0] ALIGN_CAP_LOG2 = 3'd7;

  // request commands
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NULL      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OOB       = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FREED     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_LAST  = 3'd5;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic accept;   // latch the request, issue the header read
    logic calc;     // form the sums and capture the header
    logic commit;   // update state, load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Padding from the current address up to the next aligned one, grown by
  // whole alignment units until it leaves room for a header.
  function automatic logic [PAD_W-1:0] pad_calc(input logic [6:0] cur_lo,
                                                input logic [2:0] lg);
    logic [9:0] a;
    logic [9:0] modv;
    logic [9:0] pad0;
    logic [9:0] need;
    logic [9:0] padv;
    a    = 10'(1) << lg;
    modv = {3'b000, cur_lo} & (a - 10'd1);
    pad0 = (modv != 10'd0) ? (a - modv) : 10'd0;
    padv = pad0;
    if (pad0 < 10'(HEADER_BYTES)) begin
      need = 10'(HEADER_BYTES) - pad0;
      padv = pad0 + (((need + a - 10'd1) >> lg) << lg);
    end
    return padv[PAD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/sae_req_if.sv]
// ----------------------------------------------------------------------------
// Stack allocator request channel
// Valid/ready channel carrying one allocator command.
// ----------------------------------------------------------------------------
`default_nettype none

interface sae_req_if;
  import sae_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [BYTES_W-1:0]   request_bytes;
  logic [ALIGN_W-1:0]   alignment_log2;
  logic [ADDR_W-1:0]    address;

  modport source (output valid, command, request_bytes, alignment_log2, address,
                  input ready);
  modport sink   (input valid, command, request_bytes, alignment_log2, address,
                  output ready);
endinterface

`default_nettype wire

[hdl/sae_rsp_if.sv]
// ----------------------------------------------------------------------------
// Stack allocator response channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sae_rsp_if;
  import sae_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ADDR_W-1:0]    result_address;
  logic [OFFS_W-1:0]    offset_now;

  modport source (output valid, status, result_address, offset_now,
                  input ready);
  modport sink   (input valid, status, result_address, offset_now,
                  output ready);
endinterface

`default_nettype wire

[hdl/sae_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/sae_ctrl.sv]
// ----------------------------------------------------------------------------
// Stack allocator controller
// Sequences accept, calculate and commit for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_ctrl import sae_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold until the result register can take the new result
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/sae_datapath.sv]
// ----------------------------------------------------------------------------
// Stack allocator datapath
// Offsets, header stack, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_datapath import sae_pkg::*; #(
  parameter int unsigned MAX_ALLOCS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_stat_t                   stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]            command_i,
  input  wire logic [BYTES_W-1:0]    request_bytes_i,
  input  wire logic [ALIGN_W-1:0]    alignment_log2_i,
  input  wire logic [ADDR_W-1:0]     address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STAT_W-1:0]          status_o,
  output logic [ADDR_W-1:0]          result_address_o,
  output logic [OFFS_W-1:0]          offset_now_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ALLOCS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_ALLOCS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ALLOCS);

  // configuration and allocator state
  logic [ADDR_W-1:0] base_q;
  logic [OFFS_W-1:0] pool_q;
  logic [OFFS_W-1:0] top_q, top_d;
  logic [OFFS_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // latched request
  logic [1:0]         cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [PAD_W-1:0]   pad_q;

  // intermediate sums
  logic [SUM_W-1:0]   sum_q;
  logic [ADDR_W:0]    limit_q;
  logic [ADDR_W:0]    top_addr_q;
  logic [ADDR_W:0]    tgt_q;
  logic [ADDR_W-1:0]  res_q;
  logic [OFFS_W-1:0]  hdr_prev_q;

  // result register
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [OFFS_W-1:0]  out_offs_q;

  logic [2:0]         lg_clamped;
  logic [HDR_W-1:0]   hdr_rdata;
  logic               hdr_we;
  logic [STAT_W-1:0]  status_d;
  logic [ADDR_W-1:0]  result_d;
  logic [ADDR_W:0]    addr_ext;

  assign lg_clamped = (alignment_log2_i > {1'b0, ALIGN_CAP_LOG2}) ? ALIGN_CAP_LOG2
                                                                 : alignment_log2_i[2:0];
  assign addr_ext   = {1'b0, addr_q};

  sae_ram #(
    .WIDTH (HDR_W),
    .DEPTH (MAX_ALLOCS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({pad_q, prev_q}),
    .re_i    (cmd_i.accept),
    .raddr_i (IDX_W'(cnt_q - CNT_W'(1))),
    .rdata_o (hdr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pool_q <= POOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BASE_ADDRESS: base_q <= cfg_data_i;
        REG_POOL_SIZE:    pool_q <= cfg_data_i[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and sums; no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      bytes_q <= request_bytes_i;
      addr_q  <= address_i;
      pad_q   <= pad_calc(base_q[6:0] + top_q[6:0], lg_clamped);
    end
    if (cmd_i.calc) begin
      sum_q      <= SUM_W'(top_q) + SUM_W'(pad_q) + SUM_W'(bytes_q);
      limit_q    <= {1'b0, base_q} + (ADDR_W + 1)'(pool_q);
      top_addr_q <= {1'b0, base_q} + (ADDR_W + 1)'(top_q);
      tgt_q      <= {1'b0, base_q} + (ADDR_W + 1)'(prev_q)
                    + (ADDR_W + 1)'(hdr_rdata[HDR_W-1:OFFS_W]);
      res_q      <= base_q + ADDR_W'(top_q) + ADDR_W'(pad_q);
      hdr_prev_q <= hdr_rdata[OFFS_W-1:0];
    end
  end

  // decision on the captured sums
  always_comb begin
    top_d    = top_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    status_d = STAT_OK;
    result_d = '0;
    hdr_we   = 1'b0;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (sum_q > SUM_W'(pool_q)) begin
          status_d = STAT_OVERFLOW;
        end else if (cnt_q >= CNT_MAX) begin
          status_d = STAT_FULL;
        end else begin
          hdr_we   = cmd_i.commit;
          cnt_d    = cnt_q + CNT_W'(1);
          prev_d   = top_q;
          top_d    = sum_q[OFFS_W-1:0];
          result_d = res_q;
        end
      end
      CMD_FREE: begin
        if (addr_q == '0) begin
          status_d = STAT_NULL;
        end else if (addr_q < base_q || addr_ext >= limit_q) begin
          status_d = STAT_OOB;
        end else if (addr_ext >= top_addr_q) begin
          status_d = STAT_FREED;
        end else if (cnt_q == '0 || addr_ext != tgt_q) begin
          status_d = STAT_NOT_LAST;
        end else begin
          top_d  = prev_q;
          prev_d = hdr_prev_q;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      CMD_RESET: begin
        top_d  = '0;
        prev_d = '0;
        cnt_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      top_q  <= top_d;
      prev_q <= prev_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_addr_q   <= result_d;
      out_offs_q   <= top_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_address_o = out_addr_q;
  assign offset_now_o     = out_offs_q;

endmodule

`default_nettype wire

[hdl/stack_allocator_engine_top.sv]
// ----------------------------------------------------------------------------
// Stack allocator engine top level
// Bump-pointer allocator with a bounded header stack over a configured pool.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                payload
//  req_i    in   req_i.valid/ready        command, request_bytes,
//                                         alignment_log2, address
//  rsp_o    out  rsp_o.valid/ready        status, result_address, offset_now
//  cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  A request passes through three steps: accept (header read issued), calculate
//  (registered header RAM read, wide sums), commit. The header RAM read and
//  the 33-bit address sums set this division into steps.
//  A new request is accepted only in the idle state; commit waits while the
//  result register still holds an untaken result.
//  Reset clears offsets, header count and base address, sets pool size to POOL_MAX; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_allocator_engine_top_defines.svh"

module stack_allocator_engine_top import sae_pkg::*; #(
  parameter int unsigned MAX_ALLOCS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sae_req_if.sink                    req_i,
  sae_rsp_if.source                  rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  logic      req_ready;

  assign cfg_ready_o = 1'b1;
  assign req_i.ready = req_ready;

  sae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  sae_datapath #(
    .MAX_ALLOCS (MAX_ALLOCS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (req_i.command),
    .request_bytes_i  (req_i.request_bytes),
    .alignment_log2_i (req_i.alignment_log2),
    .address_i        (req_i.address),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .status_o         (rsp_o.status),
    .result_address_o (rsp_o.result_address),
    .offset_now_o     (rsp_o.offset_now)
  );

  // a failed or non-allocating transaction returns a null address
  `SAE_ASSERT_SAME(a_fail_null_addr, clk_i, rst_ni, rsp_o.valid && rsp_o.status != STAT_OK, rsp_o.result_address == '0, "failed transaction carries an address")

  // one request at a time: no accept straight after an accept
  `SAE_ASSERT_NEXT(a_single_issue, clk_i, rst_ni, req_i.valid && req_ready, !req_ready, "request accepted while busy")

  // a fresh result follows a busy cycle
  `SAE_ASSERT_SAME(a_result_after_work, clk_i, rst_ni, $rose(rsp_o.valid), $past(!req_ready), "result appeared without work")

endmodule

`default_nettype wire
